@@ sv/ifl_pkg.sv @@
// Package for the indexed free-list record store.
// Holds the action and error codes and the default sizes; depends on nothing.
`default_nettype none

package ifl_pkg;

    // Fixed widths of the beat fields.
    localparam int ACTION_W = 3;
    localparam int ERROR_W  = 2;
    localparam int DATA_W   = 32;

    // Default sizes for the top-level parameters.
    localparam int DEF_MAX_RECORDS = 256;
    localparam int DEF_MAX_FIELDS  = 4;

    // Link word written into field 0 when an erased record ends the free list.
    localparam logic [DATA_W-1:0] NO_LINK = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_GET       = 3'd0,
        ACT_SET       = 3'd1,
        ACT_INSERT    = 3'd2,
        ACT_ERASE     = 3'd3,
        ACT_PUSH_BACK = 3'd4,
        ACT_POP_BACK  = 3'd5,
        ACT_CLEAR     = 3'd6
    } t_action;

    typedef enum logic [ERROR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2
    } t_error;

endpackage

`default_nettype wire

@@ sv/indexed_free_list_record_store.sv @@
// Top level of the indexed free-list record store.
// Depends on ifl_pkg (codes, default sizes) and ifl_ram (record word store).
`default_nettype none

// The block keeps up to MAX_RECORDS records of a configurable number of 32-bit
// fields in one word RAM addressed as record * fields + field, together with a
// record count and the head of a free list whose links live in field 0 of erased
// records. It takes one action beat per clock cycle while its input is not stalled and
// returns exactly one result beat per action, in order. A result is presented from the
// output register after its action beat has passed the action register: the accepting
// edge captures the action and issues the RAM read that it needs (the field for get, the
// head's link for insert), and the committing edge applies the action to the count, the
// free list and the RAM and loads the output register. The sustained rate is one action
// per cycle as long as the output side takes results; the RAM's single read port, read
// as the beat is accepted, sets that figure. A write by one action to the word that the
// next action reads is forwarded, so back-to-back set/get and erase/insert pairs see the
// new data. The word store has no reset and needs no clearing pass: a field must be
// written before it is read. The field count register must be written only while the
// block is idle; the block does not enforce it. A value of zero acts as one and a value above MAX_FIELDS as MAX_FIELDS.
module indexed_free_list_record_store #(
    parameter int MAX_RECORDS = ifl_pkg::DEF_MAX_RECORDS,
    parameter int MAX_FIELDS  = ifl_pkg::DEF_MAX_FIELDS,
    localparam int REC_W = $clog2(MAX_RECORDS),
    localparam int CNT_W = $clog2(MAX_RECORDS + 1),
    localparam int FLD_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1,
    localparam int CFG_W = $clog2(MAX_FIELDS + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]                  i_cfg_wr_data,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [ifl_pkg::ACTION_W-1:0]      i_action,
    input  wire logic [REC_W-1:0]                  i_record,
    input  wire logic [FLD_W-1:0]                  i_field_sel,
    input  wire logic signed [ifl_pkg::DATA_W-1:0] i_value,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [ifl_pkg::DATA_W-1:0]      o_read_value,
    output logic [REC_W-1:0]                       o_index,
    output logic [CNT_W-1:0]                       o_count,
    output logic [ifl_pkg::ERROR_W-1:0]            o_error
);

    localparam int DEPTH = MAX_RECORDS * MAX_FIELDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = REC_W + CFG_W + 1;
    localparam int CW    = CFG_W + FLD_W;
    localparam int DW    = ifl_pkg::DATA_W;

    // Configuration: the field count is stored already clamped to 1..MAX_FIELDS.
    logic [CFG_W-1:0] r_nf;

    // Block state.
    logic [CNT_W-1:0] r_count;
    logic [REC_W-1:0] r_free_head;
    logic             r_free_valid;
    logic [CNT_W-1:0] n_count;
    logic [REC_W-1:0] n_free_head;
    logic             n_free_valid;

    // Action register: the beat being worked on, with its RAM read in flight.
    logic                 r_a_vld;
    ifl_pkg::t_action     r_a_action;
    logic [REC_W-1:0]     r_a_record;
    logic [FLD_W-1:0]     r_a_field;
    logic [DW-1:0]        r_a_value;

    // Output register.
    logic                 r_o_vld;

    // RAM read side and forwarding of a write to the word read next.
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        r_rd_addr;
    logic [DW-1:0]        ram_rdata;
    logic                 r_byp_hit;
    logic [DW-1:0]        r_byp_data;
    logic [DW-1:0]        rdata;

    // Write side, decided by the action register.
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [DW-1:0]        wr_data;

    // Result of the action register.
    logic [DW-1:0]        res_read;
    logic [REC_W-1:0]     res_index;
    ifl_pkg::t_error      res_error;

    logic                 commit;
    logic                 in_accept;
    logic                 out_accept;

    // Address arithmetic.
    logic [REC_W-1:0]     rd_rec;
    logic [FLD_W-1:0]     rd_fld;
    logic [PW-1:0]        rd_prod;
    logic [FLD_W-1:0]     wr_fld;
    logic [PW-1:0]        wr_prod;
    logic                 a_rec_bad;
    logic                 a_fld_bad;
    logic                 a_full;

    // Handshake. The action register advances whenever the output register is
    // free or is being emptied in the same cycle.
    assign out_accept = r_o_vld && !i_out_stall;
    assign commit     = r_a_vld && (!r_o_vld || !i_out_stall);
    assign o_in_stall = r_a_vld && !commit;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_out_valid = r_o_vld;

    // Checks on the beat in the action register, against the state that all
    // earlier beats have left.
    assign a_rec_bad = ({{(CNT_W - REC_W){1'b0}}, r_a_record} >= r_count);
    assign a_fld_bad = ({{(CW - FLD_W){1'b0}}, r_a_field} >= {{(CW - CFG_W){1'b0}}, r_nf});
    assign a_full    = (r_count >= CNT_W'(MAX_RECORDS));

    // Forwarded read data: a write by the previous beat to this beat's word.
    assign rdata = r_byp_hit ? r_byp_data : ram_rdata;

    // Write address: set writes its field, erase writes field 0 of the record.
    assign wr_fld  = (r_a_action == ifl_pkg::ACT_SET) ? r_a_field : '0;
    assign wr_prod = PW'(r_a_record) * PW'(r_nf) + PW'(wr_fld);
    assign wr_addr = wr_prod[AW-1:0];

    always_comb begin
        n_count      = r_count;
        n_free_head  = r_free_head;
        n_free_valid = r_free_valid;
        wr_en        = 1'b0;
        wr_data      = r_a_value;
        res_read     = '0;
        res_index    = '0;
        res_error    = ifl_pkg::ERR_OK;
        if (r_a_vld) begin
            case (r_a_action)
                ifl_pkg::ACT_GET: begin
                    if (a_rec_bad || a_fld_bad) begin
                        res_error = ifl_pkg::ERR_RANGE;
                    end else begin
                        res_read = rdata;
                    end
                end
                ifl_pkg::ACT_SET: begin
                    if (a_rec_bad || a_fld_bad) begin
                        res_error = ifl_pkg::ERR_RANGE;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
                ifl_pkg::ACT_INSERT: begin
                    if (r_free_valid) begin
                        // Pop the head; its link was read when the beat arrived.
                        res_index = r_free_head;
                        if (rdata < DW'(MAX_RECORDS)) begin
                            n_free_head = rdata[REC_W-1:0];
                        end else begin
                            n_free_valid = 1'b0;
                            n_free_head  = '0;
                        end
                    end else if (a_full) begin
                        res_error = ifl_pkg::ERR_FULL;
                    end else begin
                        res_index = r_count[REC_W-1:0];
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                ifl_pkg::ACT_ERASE: begin
                    if (a_rec_bad) begin
                        res_error = ifl_pkg::ERR_RANGE;
                    end else begin
                        wr_en        = 1'b1;
                        wr_data      = r_free_valid ? DW'(r_free_head) : ifl_pkg::NO_LINK;
                        n_free_head  = r_a_record;
                        n_free_valid = 1'b1;
                    end
                end
                ifl_pkg::ACT_PUSH_BACK: begin
                    if (a_full) begin
                        res_error = ifl_pkg::ERR_FULL;
                    end else begin
                        res_index = r_count[REC_W-1:0];
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                ifl_pkg::ACT_POP_BACK: begin
                    if (r_count == '0) begin
                        res_error = ifl_pkg::ERR_RANGE;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                ifl_pkg::ACT_CLEAR: begin
                    n_count      = '0;
                    n_free_valid = 1'b0;
                    n_free_head  = '0;
                end
                default: begin
                    // The unused action code does nothing and reports no error.
                end
            endcase
        end
    end

    // Read address for the beat being accepted. Insert reads the link in field 0
    // of the free-list head as it stands after the beat now committing; any other
    // action reads its own field. Without a new beat the held address is re-read,
    // so a stalled beat keeps its data.
    always_comb begin
        if (i_action == ifl_pkg::ACT_INSERT) begin
            rd_rec = commit ? n_free_head : r_free_head;
            rd_fld = '0;
        end else begin
            rd_rec = i_record;
            rd_fld = i_field_sel;
        end
        rd_prod = PW'(rd_rec) * PW'(r_nf) + PW'(rd_fld);
        rd_addr = in_accept ? rd_prod[AW-1:0] : r_rd_addr;
    end

    ifl_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (commit && wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nf         <= CFG_W'(1);
            r_count      <= '0;
            r_free_head  <= '0;
            r_free_valid <= 1'b0;
            r_a_vld      <= 1'b0;
            r_o_vld      <= 1'b0;
            r_byp_hit    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_wr_data == '0) begin
                    r_nf <= CFG_W'(1);
                end else if (i_cfg_wr_data > CFG_W'(MAX_FIELDS)) begin
                    r_nf <= CFG_W'(MAX_FIELDS);
                end else begin
                    r_nf <= i_cfg_wr_data;
                end
            end
            if (commit) begin
                r_count      <= n_count;
                r_free_head  <= n_free_head;
                r_free_valid <= n_free_valid;
            end
            if (in_accept) begin
                r_a_vld <= 1'b1;
            end else if (commit) begin
                r_a_vld <= 1'b0;
            end
            if (commit) begin
                r_o_vld <= 1'b1;
            end else if (out_accept) begin
                r_o_vld <= 1'b0;
            end
            r_byp_hit <= commit && wr_en && (wr_addr == rd_addr);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_addr  <= rd_addr;
        r_byp_data <= wr_data;
        if (in_accept) begin
            r_a_action <= ifl_pkg::t_action'(i_action);
            r_a_record <= i_record;
            r_a_field  <= i_field_sel;
            r_a_value  <= i_value;
        end
        if (commit) begin
            o_read_value <= res_read;
            o_index      <= res_index;
            o_count      <= n_count;
            o_error      <= res_error;
        end
    end

    // The record count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("record count above capacity");

    // An empty free list always has a zero head.
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_free_valid |-> (r_free_head == '0))
        else $error("free-list head not zero while the list is empty");

    // Forwarded data only ever comes from a write by the beat that just committed.
    a_byp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp_hit |-> $past(commit && wr_en))
        else $error("forwarding without a preceding write");

    // A waiting result always shows the count that the block now holds.
    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (o_count == r_count))
        else $error("result count differs from the stored count");

    // Input is held back only while a beat sits in the action register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_a_vld && r_o_vld && i_out_stall))
        else $error("input stalled without a blocked beat");

endmodule

`default_nettype wire

@@ sv/ifl_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the record word store; depends on nothing.
`default_nettype none

module ifl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ verif/tb_indexed_free_list_record_store.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for indexed_free_list_record_store: directed table, then random
// action beats checked against an in-bench model of the store. Depends on ifl_pkg and the RTL.

module tb_indexed_free_list_record_store;

    import ifl_pkg::*;

    // Sizes follow the defaults that the instance below is built with.
    localparam int STORE_RECORDS = DEF_MAX_RECORDS;
    localparam int STORE_FIELDS  = DEF_MAX_FIELDS;
    localparam int STORE_WORDS   = STORE_RECORDS * STORE_FIELDS;

    // Action code 7 has no meaning; the block must answer it with no change and no error.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int REPORT_LINES = 40;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [7:0]          rec;
        logic [1:0]          fld;
        logic [DATA_W-1:0]   val;
    } store_op_t;

    typedef struct packed {
        logic [DATA_W-1:0]  rd;
        logic [7:0]         idx;
        logic [8:0]         cnt;
        logic [ERROR_W-1:0] err;
    } store_reply_t;

    typedef struct packed {
        store_op_t    op;
        bit           typed;
        store_reply_t want;
    } directed_row_t;

    // The directed part runs with the reset field count of one, so field 1 is already out
    // of range. Rows whose result is plain from the codes carry it typed in; the free-list
    // rows rely on the model below.
    localparam int DIRECTED_ROWS = 26;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Empty store: every access is out of range.
        '{'{ACT_GET,       8'd255, 2'd3, 32'h0000_0000}, 1'b1, '{32'h0, 8'd0, 9'd0, ERR_RANGE}},
        '{'{ACT_POP_BACK,  8'd0,   2'd0, 32'h0000_0000}, 1'b1, '{32'h0, 8'd0, 9'd0, ERR_RANGE}},
        '{'{ACT_ERASE,     8'd0,   2'd0, 32'h0000_0000}, 1'b1, '{32'h0, 8'd0, 9'd0, ERR_RANGE}},
        // Extremes of the value field written and read back.
        '{'{ACT_PUSH_BACK, 8'd0,   2'd0, 32'h0000_0000}, 1'b1, '{32'h0, 8'd0, 9'd1, ERR_OK}},
        '{'{ACT_SET,       8'd0,   2'd0, 32'h7FFF_FFFF}, 1'b1, '{32'h0, 8'd0, 9'd1, ERR_OK}},
        '{'{ACT_GET,       8'd0,   2'd0, 32'h0000_0000}, 1'b1,
          '{32'h7FFF_FFFF, 8'd0, 9'd1, ERR_OK}},
        '{'{ACT_SET,       8'd0,   2'd1, 32'h0000_1234}, 1'b1, '{32'h0, 8'd0, 9'd1, ERR_RANGE}},
        '{'{ACT_PUSH_BACK, 8'd255, 2'd3, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 8'd1, 9'd2, ERR_OK}},
        '{'{ACT_SET,       8'd1,   2'd0, 32'h8000_0000}, 1'b1, '{32'h0, 8'd0, 9'd2, ERR_OK}},
        '{'{ACT_GET,       8'd1,   2'd0, 32'h0000_0000}, 1'b1,
          '{32'h8000_0000, 8'd0, 9'd2, ERR_OK}},
        // Insert with an empty free list appends.
        '{'{ACT_INSERT,    8'd0,   2'd0, 32'h0000_0000}, 1'b1, '{32'h0, 8'd2, 9'd3, ERR_OK}},
        '{'{ACT_SET,       8'd2,   2'd0, 32'hFFFF_FFFF}, 1'b0, '0},
        // Two erases chain the list, two inserts unwind it down to the end marker.
        '{'{ACT_ERASE,     8'd0,   2'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{ACT_ERASE,     8'd2,   2'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{ACT_INSERT,    8'd0,   2'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{ACT_INSERT,    8'd0,   2'd0, 32'h0000_0000}, 1'b0, '0},
        // Erasing one record twice links it to itself.
        '{'{ACT_ERASE,     8'd1,   2'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{ACT_ERASE,     8'd1,   2'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{ACT_INSERT,    8'd0,   2'd0, 32'h0000_0000}, 1'b0, '0},
        // A link overwritten with an out-of-range word empties the list.
        '{'{ACT_SET,       8'd1,   2'd0, 32'h0000_0100}, 1'b0, '0},
        '{'{ACT_INSERT,    8'd0,   2'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{ACT_UNUSED,    8'd255, 2'd3, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 8'd0, 9'd3, ERR_OK}},
        // A record dropped by pop_back is still handed out from the free list.
        '{'{ACT_ERASE,     8'd2,   2'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{ACT_POP_BACK,  8'd0,   2'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{ACT_INSERT,    8'd0,   2'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{ACT_CLEAR,     8'd0,   2'd0, 32'h0000_0000}, 1'b1, '{32'h0, 8'd0, 9'd0, ERR_OK}}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [2:0]                i_cfg_wr_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [ACTION_W-1:0]       i_action;
    logic [7:0]                i_record;
    logic [1:0]                i_field_sel;
    logic signed [DATA_W-1:0]  i_value;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [DATA_W-1:0]  o_read_value;
    logic [7:0]                o_index;
    logic [8:0]                o_count;
    logic [ERROR_W-1:0]        o_error;

    indexed_free_list_record_store dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_record      (i_record),
        .i_field_sel   (i_field_sel),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_value  (o_read_value),
        .o_index       (o_index),
        .o_count       (o_count),
        .o_error       (o_error)
    );

    // Model of the store. The word array mirrors the RAM; word_written marks the words that
    // have been written at least once, so that the stimulus never reads an undefined word.
    logic [DATA_W-1:0] record_words [STORE_WORDS];
    bit                word_written [STORE_WORDS];
    int unsigned       live_records = 0;
    logic [7:0]        free_top = '0;
    bit                free_nonempty = 1'b0;
    logic [2:0]        field_cfg = 3'd1;

    store_reply_t expected_replies [$];

    // Run bookkeeping. idle_odds of N gives each side a one-in-N chance per beat of idling
    // for a burst; zero switches idling off.
    int unsigned idle_odds = 4;
    bit          long_hold_req = 1'b0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned full_errors = 0;
    int unsigned range_errors = 0;
    bit          store_filled = 1'b0;
    int unsigned cycle_count = 0;

    // Field counts of zero and above the maximum are clamped, as in the block.
    function automatic int unsigned fields_in_use();
        if (field_cfg == 3'd0)
            return 1;
        if (field_cfg > STORE_FIELDS)
            return STORE_FIELDS;
        return 32'(field_cfg);
    endfunction

    // Applies one action to the model and returns the result that the block must give.
    function automatic store_reply_t predict_reply(input store_op_t op);
        store_reply_t r;
        int unsigned  nf;
        int unsigned  a;
        logic [DATA_W-1:0] link;
        nf = fields_in_use();
        r = '0;
        case (op.act)
            ACT_GET, ACT_SET: begin
                if (op.rec >= live_records || op.fld >= nf) begin
                    r.err = ERR_RANGE;
                end else begin
                    a = op.rec * nf + op.fld;
                    if (op.act == ACT_GET) begin
                        r.rd = record_words[a];
                    end else begin
                        record_words[a] = op.val;
                        word_written[a] = 1'b1;
                    end
                end
            end
            ACT_INSERT: begin
                if (free_nonempty) begin
                    // Pop the head; a link that is not a record number ends the list.
                    link = record_words[free_top * nf];
                    r.idx = free_top;
                    if (link < STORE_RECORDS) begin
                        free_top = link[7:0];
                    end else begin
                        free_nonempty = 1'b0;
                        free_top = '0;
                    end
                end else if (live_records >= STORE_RECORDS) begin
                    r.err = ERR_FULL;
                end else begin
                    r.idx = live_records[7:0];
                    live_records++;
                end
            end
            ACT_ERASE: begin
                if (op.rec >= live_records) begin
                    r.err = ERR_RANGE;
                end else begin
                    a = op.rec * nf;
                    record_words[a] = free_nonempty ? {24'd0, free_top} : NO_LINK;
                    word_written[a] = 1'b1;
                    free_top = op.rec;
                    free_nonempty = 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (live_records >= STORE_RECORDS) begin
                    r.err = ERR_FULL;
                end else begin
                    r.idx = live_records[7:0];
                    live_records++;
                end
            end
            ACT_POP_BACK: begin
                if (live_records == 0)
                    r.err = ERR_RANGE;
                else
                    live_records--;
            end
            ACT_CLEAR: begin
                live_records = 0;
                free_nonempty = 1'b0;
                free_top = '0;
            end
            default: begin
            end
        endcase
        r.cnt = live_records[8:0];
        return r;
    endfunction

    // Draws a random action from the current model state. The filling mix leans hard on
    // push_back and insert so that the store reaches its capacity.
    function automatic store_op_t draw_op(input bit filling);
        store_op_t   op;
        int unsigned nf;
        int unsigned pick;
        nf = fields_in_use();
        pick = $urandom_range(0, 99);
        if (filling) begin
            if (pick < 65)      op.act = ACT_PUSH_BACK;
            else if (pick < 85) op.act = ACT_INSERT;
            else if (pick < 91) op.act = ACT_SET;
            else if (pick < 97) op.act = ACT_GET;
            else if (pick < 99) op.act = ACT_ERASE;
            else                op.act = ACT_POP_BACK;
        end else begin
            if (pick < 20)      op.act = ACT_GET;
            else if (pick < 40) op.act = ACT_SET;
            else if (pick < 54) op.act = ACT_INSERT;
            else if (pick < 66) op.act = ACT_ERASE;
            else if (pick < 80) op.act = ACT_PUSH_BACK;
            else if (pick < 90) op.act = ACT_POP_BACK;
            else if (pick < 93) op.act = ACT_CLEAR;
            else if (pick < 96) op.act = ACT_UNUSED;
            else                op.act = ACT_GET;
        end

        // Mostly records and fields in range, with a share of out-of-range ones.
        if (live_records != 0 && $urandom_range(0, 99) < 85)
            op.rec = 8'($urandom_range(0, live_records - 1));
        else
            op.rec = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85)
            op.fld = 2'($urandom_range(0, nf - 1));
        else
            op.fld = 2'($urandom_range(0, 3));
        // Small values in field 0 act as plausible free-list links when the record is erased
        // later or already sits on the list.
        if (op.fld == 2'd0 && $urandom_range(0, 3) == 0)
            op.val = $urandom_range(0, STORE_RECORDS + 8);
        else
            op.val = $urandom();

        // Never read a word that has not been written: such a get becomes a set of the
        // same word, and such an insert becomes a push_back.
        if (op.act == ACT_GET && op.rec < live_records && op.fld < nf
                && !word_written[op.rec * nf + op.fld])
            op.act = ACT_SET;
        if (op.act == ACT_INSERT && free_nonempty && !word_written[free_top * nf])
            op.act = ACT_PUSH_BACK;
        return op;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("mismatch at result %0d: %s is %0h, expected %0h",
                     results_seen, what, got, want);
    endtask

    // Offers one action beat, after an idle burst now and then, and returns once it has
    // been accepted. The expectation is queued as the beat is presented: a presented beat
    // is always taken, since its payload is held until then. Valid stays high on return so
    // that back-to-back beats need no gap.
    task automatic issue(input store_op_t op, input bit typed, input store_reply_t typed_reply);
        store_reply_t predicted;
        @(negedge i_clk);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        predicted = predict_reply(op);
        expected_replies.push_back(typed ? typed_reply : predicted);
        i_action    = op.act;
        i_record    = op.rec;
        i_field_sel = op.fld;
        i_value     = op.val;
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (live_records == STORE_RECORDS)
            store_filled = 1'b1;
    endtask

    // The field count may only change while the block is idle. Every action yields a
    // result, so an empty expectation queue means that nothing is left in flight.
    task automatic write_field_count(input logic [2:0] fields);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_replies.size() != 0) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = fields;
        field_cfg     = fields;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Random beats. When filling, the count of beats starts only once the store has been
    // full, so that full-store errors are certain to appear.
    task automatic run_random(input int unsigned beats, input bit filling);
        int unsigned left;
        bit          counting;
        left = beats;
        counting = !filling;
        while (left != 0) begin
            issue(draw_op(filling), 1'b0, '0);
            if (live_records == STORE_RECORDS)
                counting = 1'b1;
            if (counting)
                left--;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run is bounded by a cycle counter; the slowest correct run is well below it.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request so that the
    // pipeline backs up and the block stalls its input.
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0)
                hold_left--;
            else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                hold_left = $urandom_range(1, 16);
            i_out_stall = (hold_left > 0);
        end
    end

    // Each accepted result beat is compared field by field with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        store_reply_t want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            results_seen++;
            if (expected_replies.size() == 0) begin
                report_mismatch("result with nothing outstanding, count", 32'(o_count), '0);
            end else begin
                want = expected_replies.pop_front();
                if (o_read_value !== want.rd)
                    report_mismatch("read value", o_read_value, want.rd);
                if (o_index !== want.idx)
                    report_mismatch("index", 32'(o_index), 32'(want.idx));
                if (o_count !== want.cnt)
                    report_mismatch("count", 32'(o_count), 32'(want.cnt));
                if (o_error !== want.err)
                    report_mismatch("error", 32'(o_error), 32'(want.err));
            end
            if (o_error == ERR_FULL)
                full_errors++;
            if (o_error == ERR_RANGE)
                range_errors++;
        end
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_action      = '0;
        i_record      = '0;
        i_field_sel   = '0;
        i_value       = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table at the reset field count of one.
        idle_odds = 4;
        for (int r = 0; r < DIRECTED_ROWS; r++)
            issue(DIRECTED[r].op, DIRECTED[r].typed, DIRECTED[r].want);

        // Widest records, with the long receiver hold-off early in the phase.
        write_field_count(3'd4);
        long_hold_req = 1'b1;
        run_random(50, 1'b0);

        // A field count of zero acts as one; fill the store to capacity and beyond.
        idle_odds = 3;
        write_field_count(3'd0);
        run_random(20, 1'b1);

        idle_odds = 10;
        write_field_count(3'd2);
        run_random(40, 1'b0);

        // The last stretch runs with both sides at full rate and the count clamped to four.
        idle_odds = 0;
        write_field_count(3'd7);
        run_random(50, 1'b0);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("summary: %0d action beats, %0d result beats, field counts 1, 4, 0, 2 and 7",
                 items_sent, results_seen);
        $display("summary: %0d full-store and %0d range errors seen, store filled: %0s, %0d mismatches",
                 full_errors, range_errors, store_filled ? "yes" : "no", mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
